### rtl/cfr_pkg.sv
package cfr_pkg;

    localparam int FRAMES  = 64;
    localparam int FRAME_W = $clog2(FRAMES);
    localparam int HAND_W  = FRAME_W + 1;
    localparam int CFG_W   = 7;
    localparam int STEP_W  = CFG_W + 1;

    typedef enum logic [2:0] {
        MODE_INSTALL = 3'd0,
        MODE_TOUCH   = 3'd1,
        MODE_UNPIN   = 3'd2,
        MODE_FREE    = 3'd3,
        MODE_EVICT   = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NO_VICTIM = 2'd1,
        ST_BAD_FRAME = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        WK_INSTALL = 3'd0,
        WK_TOUCH   = 3'd1,
        WK_UNPIN   = 3'd2,
        WK_CLR_ACC = 3'd3,
        WK_CLEAR   = 3'd4
    } t_wr_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_UPDATE,
        S_WALK_RD,
        S_WALK_EVAL
    } t_state;

    typedef struct packed {
        logic file;
        logic dirty;
        logic acc;
        logic pin;
        logic occ;
    } t_marks;

    typedef struct packed {
        logic     load;
        logic     clr_steps;
        logic     wrap_hand;
        logic     rd_en;
        logic     rd_sel_hand;
        logic     wr_en;
        logic     wr_sel_hand;
        t_wr_kind wr_kind;
        logic     step;
        logic     res_en;
        t_status  res_status;
        logic     res_victim;
    } t_cmd;

    typedef struct packed {
        t_mode  mode;
        logic   bad_frame;
        logic   small_n;
        logic   walk_over;
        logic   out_free;
        t_marks marks;
    } t_sts;

endpackage

### rtl/clock_frame_replacement.sv
// Channel   Handshake                      Payload
// in        i_in_valid / o_in_stall        i_mode, i_frame, i_file_backed, i_is_write
// out       o_out_valid / i_out_stall      o_status, o_victim_frame, o_swap_writeback
// cfg       i_cfg_valid / o_cfg_ready      i_cfg_frames_in_use
//
// One item is in work at a time. Install, free, out-of-range and unknown items get their
// result in dispatch; touch and unpin also pass an update state, as they read the mark memory.
// An evict handles each hand position with a memory read, then a decision, and visits at
// most 2*min(frames_in_use, 64)+2 positions.
// Reset clears all marks at once through per-frame valid bits and puts the hand on frame one.
// A stalled result stays in the output register; a new item is taken once it is leaving.
module clock_frame_replacement (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [2:0]                  i_mode,
    input  logic [cfr_pkg::FRAME_W-1:0] i_frame,
    input  logic                        i_file_backed,
    input  logic                        i_is_write,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_status,
    output logic [cfr_pkg::FRAME_W-1:0] o_victim_frame,
    output logic                        o_swap_writeback,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [cfr_pkg::CFG_W-1:0]   i_cfg_frames_in_use
);

    cfr_pkg::t_cmd cmd;
    cfr_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    cfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cfr_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_mode              (i_mode),
        .i_frame             (i_frame),
        .i_file_backed       (i_file_backed),
        .i_is_write          (i_is_write),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_frames_in_use (i_cfg_frames_in_use),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_status            (o_status),
        .o_victim_frame      (o_victim_frame),
        .o_swap_writeback    (o_swap_writeback)
    );

endmodule

### rtl/cfr_ctrl.sv
module cfr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  cfr_pkg::t_sts i_sts,
    output cfr_pkg::t_cmd o_cmd
);

    cfr_pkg::t_state r_state;
    cfr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cfr_pkg::S_IDLE: begin
                if (i_in_valid && i_sts.out_free) begin
                    n_state = cfr_pkg::S_DISPATCH;
                end
            end
            cfr_pkg::S_DISPATCH: begin
                if (i_sts.mode == cfr_pkg::MODE_EVICT) begin
                    n_state = cfr_pkg::S_WALK_RD;
                end else if (!i_sts.bad_frame &&
                             (i_sts.mode == cfr_pkg::MODE_TOUCH ||
                              i_sts.mode == cfr_pkg::MODE_UNPIN)) begin
                    n_state = cfr_pkg::S_UPDATE;
                end else begin
                    n_state = cfr_pkg::S_IDLE;
                end
            end
            cfr_pkg::S_UPDATE: begin
                n_state = cfr_pkg::S_IDLE;
            end
            cfr_pkg::S_WALK_RD: begin
                if (i_sts.walk_over || i_sts.small_n) begin
                    n_state = cfr_pkg::S_IDLE;
                end else begin
                    n_state = cfr_pkg::S_WALK_EVAL;
                end
            end
            cfr_pkg::S_WALK_EVAL: begin
                if (!i_sts.marks.occ || i_sts.marks.pin || i_sts.marks.acc) begin
                    n_state = cfr_pkg::S_WALK_RD;
                end else begin
                    n_state = cfr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cfr_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            cfr_pkg::S_IDLE: begin
                o_in_stall = !i_sts.out_free;
                o_cmd.load = i_in_valid && i_sts.out_free;
            end
            cfr_pkg::S_DISPATCH: begin
                if (i_sts.mode == cfr_pkg::MODE_EVICT) begin
                    o_cmd.clr_steps = 1'b1;
                end else if (i_sts.mode != cfr_pkg::MODE_INSTALL &&
                             i_sts.mode != cfr_pkg::MODE_TOUCH &&
                             i_sts.mode != cfr_pkg::MODE_UNPIN &&
                             i_sts.mode != cfr_pkg::MODE_FREE) begin
                    o_cmd.res_en     = 1'b1;
                    o_cmd.res_status = cfr_pkg::ST_DONE;
                end else if (i_sts.bad_frame) begin
                    o_cmd.res_en     = 1'b1;
                    o_cmd.res_status = cfr_pkg::ST_BAD_FRAME;
                end else if (i_sts.mode == cfr_pkg::MODE_INSTALL) begin
                    o_cmd.wr_en      = 1'b1;
                    o_cmd.wr_kind    = cfr_pkg::WK_INSTALL;
                    o_cmd.res_en     = 1'b1;
                    o_cmd.res_status = cfr_pkg::ST_DONE;
                end else if (i_sts.mode == cfr_pkg::MODE_FREE) begin
                    o_cmd.wr_en      = 1'b1;
                    o_cmd.wr_kind    = cfr_pkg::WK_CLEAR;
                    o_cmd.res_en     = 1'b1;
                    o_cmd.res_status = cfr_pkg::ST_DONE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                end
            end
            cfr_pkg::S_UPDATE: begin
                o_cmd.wr_en      = i_sts.marks.occ;
                o_cmd.wr_kind    = (i_sts.mode == cfr_pkg::MODE_TOUCH) ?
                                   cfr_pkg::WK_TOUCH : cfr_pkg::WK_UNPIN;
                o_cmd.res_en     = 1'b1;
                o_cmd.res_status = cfr_pkg::ST_DONE;
            end
            cfr_pkg::S_WALK_RD: begin
                if (i_sts.walk_over) begin
                    o_cmd.res_en     = 1'b1;
                    o_cmd.res_status = cfr_pkg::ST_NO_VICTIM;
                end else begin
                    o_cmd.wrap_hand = 1'b1;
                    if (i_sts.small_n) begin
                        o_cmd.res_en     = 1'b1;
                        o_cmd.res_status = cfr_pkg::ST_NO_VICTIM;
                    end else begin
                        o_cmd.rd_en       = 1'b1;
                        o_cmd.rd_sel_hand = 1'b1;
                    end
                end
            end
            cfr_pkg::S_WALK_EVAL: begin
                o_cmd.wr_sel_hand = 1'b1;
                if (!i_sts.marks.occ || i_sts.marks.pin) begin
                    o_cmd.step = 1'b1;
                end else if (i_sts.marks.acc) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_kind = cfr_pkg::WK_CLR_ACC;
                    o_cmd.step    = 1'b1;
                end else begin
                    o_cmd.wr_en      = 1'b1;
                    o_cmd.wr_kind    = cfr_pkg::WK_CLEAR;
                    o_cmd.res_en     = 1'b1;
                    o_cmd.res_status = cfr_pkg::ST_DONE;
                    o_cmd.res_victim = 1'b1;
                end
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

### rtl/cfr_datapath.sv
module cfr_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cfr_pkg::t_cmd               i_cmd,
    output cfr_pkg::t_sts               o_sts,
    input  logic [2:0]                  i_mode,
    input  logic [cfr_pkg::FRAME_W-1:0] i_frame,
    input  logic                        i_file_backed,
    input  logic                        i_is_write,
    input  logic                        i_cfg_valid,
    input  logic [cfr_pkg::CFG_W-1:0]   i_cfg_frames_in_use,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [1:0]                  o_status,
    output logic [cfr_pkg::FRAME_W-1:0] o_victim_frame,
    output logic                        o_swap_writeback
);

    cfr_pkg::t_mode                r_mode;
    logic [cfr_pkg::FRAME_W-1:0]   r_frame;
    logic                          r_fb;
    logic                          r_wr;
    logic [cfr_pkg::CFG_W-1:0]     r_cfg;
    logic [cfr_pkg::HAND_W-1:0]    r_hand;
    logic [cfr_pkg::STEP_W-1:0]    r_steps;
    logic [cfr_pkg::FRAMES-1:0]    r_valid;
    cfr_pkg::t_marks               r_mem [cfr_pkg::FRAMES];
    cfr_pkg::t_marks               r_rd_data;
    logic                          r_rd_valid;
    logic                          r_out_valid;
    cfr_pkg::t_status              r_out_status;
    logic [cfr_pkg::FRAME_W-1:0]   r_out_victim;
    logic                          r_out_swap;

    logic [cfr_pkg::CFG_W-1:0]     eff;
    logic [cfr_pkg::HAND_W-1:0]    hand_eff;
    logic [cfr_pkg::STEP_W-1:0]    step_limit;
    logic [cfr_pkg::FRAME_W-1:0]   rd_addr;
    logic [cfr_pkg::FRAME_W-1:0]   wr_addr;
    cfr_pkg::t_marks               rd_marks;
    cfr_pkg::t_marks               wr_data;

    assign eff = (r_cfg < cfr_pkg::CFG_W'(cfr_pkg::FRAMES)) ?
                 r_cfg : cfr_pkg::CFG_W'(cfr_pkg::FRAMES);
    assign hand_eff = (r_hand >= cfr_pkg::HAND_W'(eff)) ?
                      cfr_pkg::HAND_W'(1) : r_hand;
    assign step_limit = {eff, 1'b0} + cfr_pkg::STEP_W'(2);
    assign rd_addr = i_cmd.rd_sel_hand ? hand_eff[cfr_pkg::FRAME_W-1:0] : r_frame;
    assign wr_addr = i_cmd.wr_sel_hand ? r_hand[cfr_pkg::FRAME_W-1:0] : r_frame;
    assign rd_marks = r_rd_valid ? r_rd_data : '0;

    always_comb begin
        wr_data = rd_marks;
        unique case (i_cmd.wr_kind)
            cfr_pkg::WK_INSTALL: begin
                wr_data      = '0;
                wr_data.occ  = 1'b1;
                wr_data.pin  = 1'b1;
                wr_data.file = r_fb;
            end
            cfr_pkg::WK_TOUCH: begin
                wr_data.acc   = 1'b1;
                wr_data.dirty = rd_marks.dirty | r_wr;
            end
            cfr_pkg::WK_UNPIN: begin
                wr_data.pin = 1'b0;
            end
            cfr_pkg::WK_CLR_ACC: begin
                wr_data.acc = 1'b0;
            end
            default: begin
                wr_data = '0;
            end
        endcase
    end

    always_comb begin
        o_sts           = '0;
        o_sts.mode      = r_mode;
        o_sts.bad_frame = (r_frame == '0) ||
                          (cfr_pkg::CFG_W'(r_frame) >= eff);
        o_sts.small_n   = eff < cfr_pkg::CFG_W'(2);
        o_sts.walk_over = r_steps >= step_limit;
        o_sts.out_free  = !r_out_valid || !i_out_stall;
        o_sts.marks     = rd_marks;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= cfr_pkg::t_mode'(i_mode);
            r_frame <= i_frame;
            r_fb    <= i_file_backed;
            r_wr    <= i_is_write;
        end
        if (i_cmd.rd_en) begin
            r_rd_data  <= r_mem[rd_addr];
            r_rd_valid <= r_valid[rd_addr];
        end
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.res_en) begin
            r_out_status <= i_cmd.res_status;
            r_out_victim <= i_cmd.res_victim ? r_hand[cfr_pkg::FRAME_W-1:0] : '0;
            r_out_swap   <= i_cmd.res_victim && (!rd_marks.file || rd_marks.dirty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= cfr_pkg::CFG_W'(cfr_pkg::FRAMES);
            r_hand      <= cfr_pkg::HAND_W'(1);
            r_steps     <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_frames_in_use;
            end
            if (i_cmd.clr_steps) begin
                r_steps <= '0;
            end else if (i_cmd.step) begin
                r_steps <= r_steps + cfr_pkg::STEP_W'(1);
            end
            if (i_cmd.step) begin
                r_hand <= r_hand + cfr_pkg::HAND_W'(1);
            end else if (i_cmd.wrap_hand) begin
                r_hand <= hand_eff;
            end
            if (i_cmd.wr_en) begin
                r_valid[wr_addr] <= (i_cmd.wr_kind != cfr_pkg::WK_CLEAR);
            end
            if (i_cmd.res_en) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_victim_frame   = r_out_victim;
    assign o_swap_writeback = r_out_swap;

endmodule
